[rtl/q2e_pkg.sv]
`default_nettype none
package q2e_pkg;
    localparam int ANG_W = 26;
    localparam int HALF_TURN = 4608000;
    localparam int HALF_TURN_CD = 18000;
    localparam int QUARTER_TURN_CD = 9000;
    localparam int CV_W = 44;

    function automatic logic [ANG_W-1:0] atan_tab(input int i);
        logic [ANG_W-1:0] r;
        begin
            case (i)
                0: r = 26'd1152000;
                1: r = 26'd680065;
                2: r = 26'd359328;
                3: r = 26'd182400;
                4: r = 26'd91554;
                5: r = 26'd45822;
                6: r = 26'd22916;
                7: r = 26'd11459;
                8: r = 26'd5730;
                9: r = 26'd2865;
                10: r = 26'd1432;
                11: r = 26'd716;
                12: r = 26'd358;
                13: r = 26'd179;
                14: r = 26'd90;
                15: r = 26'd45;
                16: r = 26'd22;
                17: r = 26'd11;
                18: r = 26'd6;
                19: r = 26'd3;
                20: r = 26'd1;
                21: r = 26'd1;
                default: r = '0;
            endcase
            atan_tab = r;
        end
    endfunction
endpackage
`default_nettype wire

[rtl/quaternion_to_euler_angles_unit.sv]
`default_nettype none
// Quaternion to roll/pitch/yaw in centidegrees. Fully pipelined: one beat
// accepted per cycle while the output is not stalled. In order: scaling,
// products, sums, asin clamp, the radicand and bit-serial pitch square
// root (one root bit per stage), an align register, then the CORDIC (one
// pre-stage plus CORDIC_STAGES) and the output register. A single global
// enable (not stalled output) advances all stages, so a stalled result
// freezes the whole pipe and holds off the input.
module quaternion_to_euler_angles_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_q_w,
    input  wire logic signed [31:0] i_q_x,
    input  wire logic signed [31:0] i_q_y,
    input  wire logic signed [31:0] i_q_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_roll_centideg,
    output logic signed [14:0]      o_pitch_centideg,
    output logic signed [15:0]      o_yaw_centideg,
    output logic                    o_zero_quaternion
);
    import q2e_pkg::*;

    localparam int SQ = 32;                  // root bits
    localparam int LAT = 8 + SQ + CORDIC_STAGES;

    logic en;
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
    end
    assign o_valid = r_vld[LAT-1];

    // stage 1: normalize so the largest magnitude is in [2^29, 2^30)
    logic [31:0] m [4];
    logic [31:0] sc [4];
    logic sg [4];
    logic [31:0] mmax;
    logic [5:0] lz;
    logic signed [31:0] r_a [4];
    logic r_zq1;
    always_comb begin
        m[0] = i_q_w[31] ? 32'(-i_q_w) : i_q_w;
        m[1] = i_q_x[31] ? 32'(-i_q_x) : i_q_x;
        m[2] = i_q_y[31] ? 32'(-i_q_y) : i_q_y;
        m[3] = i_q_z[31] ? 32'(-i_q_z) : i_q_z;
        sg[0] = i_q_w[31];
        sg[1] = i_q_x[31];
        sg[2] = i_q_y[31];
        sg[3] = i_q_z[31];
        mmax = m[0];
        for (int k = 1; k < 4; k++) if (m[k] > mmax) mmax = m[k];
        lz = 6'd32;
        for (int b = 0; b < 32; b++) if (mmax[b]) lz = 6'(31 - b);
        for (int k = 0; k < 4; k++) begin
            sc[k] = (lz >= 6'd2) ? (m[k] << (lz - 6'd2)) : (m[k] >> (6'd2 - lz));
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zq1 <= (mmax == 32'd0);
            for (int k = 0; k < 4; k++) begin
                r_a[k] <= sg[k] ? -$signed(sc[k]) : $signed(sc[k]);
            end
        end
    end

    // stage 2: products
    logic signed [63:0] r_p [10];
    logic r_zq2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zq2 <= r_zq1;
            r_p[0] <= r_a[0] * r_a[0];
            r_p[1] <= r_a[1] * r_a[1];
            r_p[2] <= r_a[2] * r_a[2];
            r_p[3] <= r_a[3] * r_a[3];
            r_p[4] <= r_a[0] * r_a[2];
            r_p[5] <= r_a[1] * r_a[3];
            r_p[6] <= r_a[0] * r_a[3];
            r_p[7] <= r_a[1] * r_a[2];
            r_p[8] <= r_a[2] * r_a[3];
            r_p[9] <= r_a[0] * r_a[1];
        end
    end

    // stage 3: sums
    logic signed [63:0] r_yr, r_xr, r_yy, r_xy, r_n, r_s;
    logic r_zq3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zq3 <= r_zq2;
            r_yr <= (r_p[4] - r_p[5]) <<< 1;
            r_xr <= r_p[0] - r_p[1] - r_p[2] + r_p[3];
            r_yy <= (r_p[6] - r_p[7]) <<< 1;
            r_xy <= r_p[0] - r_p[1] + r_p[2] - r_p[3];
            r_n  <= r_p[0] + r_p[1] + r_p[2] + r_p[3];
            r_s  <= (r_p[8] + r_p[9]) <<< 1;
        end
    end

    // stage 4: clamp, shift n below 2^31
    logic signed [63:0] cs;
    logic [63:0] nn, sm;
    logic [6:0] nl;
    logic [31:0] n31, s31;
    always_comb begin
        cs = r_s;
        if (cs > r_n) cs = r_n;
        if (cs < -r_n) cs = -r_n;
        nn = 64'(r_n);
        sm = cs[63] ? 64'(-cs) : 64'(cs);
        nl = '0;
        for (int b = 31; b < 64; b++) if (nn[b]) nl = 7'(b - 30);
        n31 = 32'(nn >> nl);
        s31 = 32'(sm >> nl);
    end

    logic [31:0] r_n31, r_s31;
    logic r_sng, r_zq4;
    logic signed [63:0] r_yr4, r_xr4, r_yy4, r_xy4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n31 <= n31;
            r_s31 <= s31;
            r_sng <= cs[63];
            r_yr4 <= r_yr; r_xr4 <= r_xr;
            r_yy4 <= r_yy; r_xy4 <= r_xy;
            r_zq4 <= r_zq3;
        end
    end

    // sqrt pipeline: radicand first, then one result bit per stage
    logic [63:0] r_rad [SQ+1];
    logic [63:0] r_rem [SQ+1];
    logic [31:0] r_rt [SQ+1];
    logic signed [63:0] r_ps [SQ+1];
    logic signed [63:0] r_ry [SQ+1], r_rx [SQ+1], r_wy [SQ+1], r_wx [SQ+1];
    logic r_zq [SQ+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad[0] <= 64'(r_n31 - r_s31) * 64'(r_n31 + r_s31);
            r_rem[0] <= '0;
            r_rt[0] <= '0;
            r_ps[0] <= r_sng ? -$signed({32'd0, r_s31}) : $signed({32'd0, r_s31});
            r_ry[0] <= r_yr4; r_rx[0] <= r_xr4;
            r_wy[0] <= r_yy4; r_wx[0] <= r_xy4;
            r_zq[0] <= r_zq4;
        end
    end
    for (genvar g = 0; g < SQ; g++) begin : g_sq
        logic [65:0] rem2, trial;
        always_comb begin
            rem2 = {r_rem[g], r_rad[g][63:62]};
            trial = {32'd0, r_rt[g], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rad[g+1] <= r_rad[g] << 2;
                if (rem2 >= trial) begin
                    r_rem[g+1] <= 64'(rem2 - trial);
                    r_rt[g+1] <= {r_rt[g][30:0], 1'b1};
                end else begin
                    r_rem[g+1] <= 64'(rem2);
                    r_rt[g+1] <= {r_rt[g][30:0], 1'b0};
                end
                r_ps[g+1] <= r_ps[g];
                r_ry[g+1] <= r_ry[g]; r_rx[g+1] <= r_rx[g];
                r_wy[g+1] <= r_wy[g]; r_wx[g+1] <= r_wx[g];
                r_zq[g+1] <= r_zq[g];
            end
        end
    end

    // align, then three CORDIC pipes
    logic signed [63:0] r_cy [3], r_cx [3];
    logic [CORDIC_STAGES+1:0] r_zd;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cy[0] <= r_ry[SQ]; r_cx[0] <= r_rx[SQ];
            r_cy[1] <= r_ps[SQ]; r_cx[1] <= {32'd0, r_rt[SQ]};
            r_cy[2] <= r_wy[SQ]; r_cx[2] <= r_wx[SQ];
            r_zd <= {r_zd[CORDIC_STAGES:0], r_zq[SQ]};
        end
    end
    logic signed [15:0] ang [3];
    for (genvar c = 0; c < 3; c++) begin : g_cd
        q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cd (
            .i_clk(i_clk), .i_en(en), .i_y(r_cy[c]), .i_x(r_cx[c]),
            .i_limit((c == 1) ? 16'(QUARTER_TURN_CD) : 16'(HALF_TURN_CD)),
            .o_ang(ang[c]));
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_zero_quaternion <= r_zd[CORDIC_STAGES+1];
            o_roll_centideg <= r_zd[CORDIC_STAGES+1] ? '0 : ang[0];
            o_pitch_centideg <= r_zd[CORDIC_STAGES+1] ? '0 : 15'(ang[1]);
            o_yaw_centideg <= r_zd[CORDIC_STAGES+1] ? '0 : ang[2];
        end
    end

`ifndef SYNTH
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("bad stall");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_roll_centideg)) else $error("hold");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_quaternion) |-> (o_yaw_centideg == 16'sd0))
        else $error("zero");
`endif
endmodule
`default_nettype wire

[rtl/q2e_cordic.sv]
`default_nettype none
// Vectoring CORDIC, one stage per register; enable-gated with the pipe.
module q2e_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [63:0]          i_y,
    input  wire logic signed [63:0]          i_x,
    input  wire logic [15:0]                 i_limit,
    output logic signed [15:0]               o_ang
);
    import q2e_pkg::*;

    // pre-stage: quadrant fold, larger magnitude normalized to [2^39, 2^40)
    logic signed [CV_W-1:0] r_x [STAGES+1];
    logic signed [CV_W-1:0] r_y [STAGES+1];
    logic signed [ANG_W-1:0] r_z [STAGES+1];
    logic [15:0] r_lim [STAGES+1];
    logic r_nul [STAGES+1];

    logic signed [63:0] n_fx, n_fy;
    logic [63:0] mx, my, mm, sx, sy;
    logic signed [ANG_W-1:0] n_z0;
    logic [6:0] lz;

    always_comb begin
        n_fx = i_x;
        n_fy = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            n_z0 = (i_y >= 0) ? ANG_W'(HALF_TURN) : -ANG_W'(HALF_TURN);
            n_fx = -i_x;
            n_fy = -i_y;
        end
        mx = n_fx[63] ? 64'(-n_fx) : 64'(n_fx);
        my = n_fy[63] ? 64'(-n_fy) : 64'(n_fy);
        mm = (mx > my) ? mx : my;
        lz = 7'd64;
        for (int b = 0; b < 64; b++) begin
            if (mm[b]) lz = 7'(63 - b);
        end
        // msb should land at bit 39, i.e. lz = 24
        if (lz >= 7'd24) begin
            sx = mx << (lz - 7'd24);
            sy = my << (lz - 7'd24);
        end else begin
            sx = mx >> (7'd24 - lz);
            sy = my >> (7'd24 - lz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_fx[63] ? -CV_W'(sx) : CV_W'(sx);
            r_y[0] <= n_fy[63] ? -CV_W'(sy) : CV_W'(sy);
            r_z[0] <= n_z0;
            r_lim[0] <= i_limit;
            r_nul[0] <= (mm == 64'd0);
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lim[g+1] <= r_lim[g];
                r_nul[g+1] <= r_nul[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + $signed(atan_tab(g));
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - $signed(atan_tab(g));
                end
            end
        end
    end

    logic signed [ANG_W-1:0] a;
    logic signed [ANG_W-1:0] lim;
    always_comb begin
        a = (r_z[STAGES] + ANG_W'(128)) >>> 8;
        lim = ANG_W'(r_lim[STAGES]);
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        o_ang = r_nul[STAGES] ? 16'sd0 : 16'(a);
    end
endmodule
`default_nettype wire

[tb/tb_top.sv]
module tb_top;
    localparam int LATENCY = 16 + 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HALF_TURN_U = 4608000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [31:0] i_q_w = '0, i_q_x = '0, i_q_y = '0, i_q_z = '0;
    logic o_stall, o_valid, o_zero_quaternion;
    logic signed [15:0] o_roll_centideg, o_yaw_centideg;
    logic signed [14:0] o_pitch_centideg;

    quaternion_to_euler_angles_unit #(.CORDIC_STAGES(16)) dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               zero;
    } angles_t;

    // ---- predictor ----
    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] fshr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    // sign-magnitude shift, truncating magnitude
    function automatic logic signed [63:0] sm_shift(input logic signed [63:0] v, input int sh);
        logic [63:0] m;
        m = mag(v);
        if (sh > 0) m = m >> sh;
        else if (sh < 0) m = m << (-sh);
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic int msb_shift(input logic [63:0] m, input int lo);
        int sh;
        sh = 0;
        while (m >= (64'd1 << (lo + 1))) begin m = m >> 1; sh++; end
        while (m < (64'd1 << lo)) begin m = m << 1; sh--; end
        return sh;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int cordic_angle(input logic signed [63:0] y,
                                        input logic signed [63:0] x, input int lim);
        logic signed [63:0] z, dx, dy, a;
        logic [63:0] mx, my;
        int sh;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN_U : -HALF_TURN_U;
            x = -x;
            y = -y;
        end
        mx = mag(x);
        my = mag(y);
        sh = msb_shift(mx > my ? mx : my, 39);
        x = sm_shift(x, sh);
        y = sm_shift(y, sh);
        for (int i = 0; i < 16; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += q2e_pkg::atan_tab(i);
            end else begin
                x -= dx; y += dy; z -= q2e_pkg::atan_tab(i);
            end
        end
        a = fshr(z + 128, 8);
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        return int'(a);
    endfunction

    function automatic angles_t quat_to_angles(input logic signed [31:0] w, x, y, z);
        logic signed [63:0] a[4];
        logic signed [63:0] n, s;
        logic [63:0] m, sm;
        angles_t r;
        int sh;
        a[0] = w; a[1] = x; a[2] = y; a[3] = z;
        m = 0;
        for (int i = 0; i < 4; i++) if (mag(a[i]) > m) m = mag(a[i]);
        r = '0;
        if (m == 0) begin
            r.zero = 1'b1;
            return r;
        end
        sh = msb_shift(m, 29);
        for (int i = 0; i < 4; i++) a[i] = sm_shift(a[i], sh);
        r.roll = 16'(cordic_angle(2 * (a[0]*a[2] - a[1]*a[3]),
                                  a[0]*a[0] - a[1]*a[1] - a[2]*a[2] + a[3]*a[3], 18000));
        r.yaw = 16'(cordic_angle(2 * (a[0]*a[3] - a[1]*a[2]),
                                 a[0]*a[0] - a[1]*a[1] + a[2]*a[2] - a[3]*a[3], 18000));
        n = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        s = 2 * (a[2]*a[3] + a[0]*a[1]);
        if (s > n) s = n;
        if (s < -n) s = -n;
        while (n >= (64'sd1 << 31)) begin
            n = n >>> 1;
            s = sm_shift(s, 1);
        end
        sm = mag(s);
        r.pitch = 15'(cordic_angle(s, $signed(int_sqrt((n - sm) * (n + sm))), 9000));
        return r;
    endfunction

    // ---- scoreboard ----
    class angle_board;
        angles_t pending[$];
        int errors = 0;
        int checked = 0;

        function void note_quat(input logic signed [31:0] w, x, y, z);
            pending.push_back(quat_to_angles(w, x, y, z));
        endfunction

        function void check_angles(input angles_t got);
            angles_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.roll !== want.roll || got.pitch !== want.pitch ||
                got.yaw !== want.yaw || got.zero !== want.zero) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d zero %0b/%0b",
                             want.roll, got.roll, want.pitch, got.pitch,
                             want.yaw, got.yaw, want.zero, got.zero);
            end
        endfunction
    endclass

    angle_board board = new();

    int cycles = 0;
    bit sending_done = 0;
    bit hold_off = 0;     // long receiver stall window
    bit calm = 0;         // no random stalls on the output side

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output checking: accepted when valid and not stalled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_angles({o_roll_centideg, o_pitch_centideg,
                                o_yaw_centideg, o_zero_quaternion});
    end

    // Receiver stall: short gaps mostly, some long, plus one forced hold-off.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_off) i_stall <= 1'b1;
        else if (calm) i_stall <= 1'b0;
        else if (r < 2) i_stall <= 1'b1;   // start of a longer stretch, cleared below
        else if (i_stall && r < 85) i_stall <= (r < 60);
        else i_stall <= (r < 20);
    end

    // Input queue of beats to send.
    logic signed [31:0] beat_q[$][4];

    task automatic push_quat(input logic signed [31:0] w, x, y, z);
        logic signed [31:0] b[4];
        b[0] = w; b[1] = x; b[2] = y; b[3] = z;
        beat_q.push_back(b);
    endtask

    function automatic logic signed [31:0] rnd_comp(input int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 0;
        endcase
    endfunction

    // Sender: drive one beat, hold it while stalled.
    task automatic send_all();
        int gap;
        while (beat_q.size() > 0) begin
            i_q_w <= beat_q[0][0];
            i_q_x <= beat_q[0][1];
            i_q_y <= beat_q[0][2];
            i_q_z <= beat_q[0][3];
            i_valid <= 1'b1;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            board.note_quat(beat_q[0][0], beat_q[0][1], beat_q[0][2], beat_q[0][3]);
            void'(beat_q.pop_front());
            gap = ($urandom_range(0, 99) < 70) ? 0 :
                  ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40));
            if (gap > 0 || beat_q.size() == 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int mode;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, axes, extremes, gimbal lock, negative x in atan2.
        push_quat(0, 0, 0, 0);
        push_quat(1, 0, 0, 0);
        push_quat(-1, 0, 0, 0);
        push_quat(0, 1, 0, 0);
        push_quat(0, 0, 1, 0);
        push_quat(0, 0, 0, 1);
        push_quat(32'sh7fffffff, 0, 0, 0);
        push_quat(32'sh80000000, 0, 0, 0);
        push_quat(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        push_quat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        push_quat(1000, 1000, 0, 0);        // pitch +90
        push_quat(1000, -1000, 0, 0);       // pitch -90
        push_quat(0, 0, 1000, 1000);
        push_quat(1, -1, 1, -1);
        push_quat(-5, 3, 7, -2);
        push_quat(0, 5, 0, -3);
        push_quat(32'sh80000000, 32'sh7fffffff, 0, 1);
        push_quat(-1, -1, -1, -1);
        push_quat(0, 0, 0, -1);
        push_quat(3, 0, 0, 32'sh80000000);
        send_all();

        // Random with a long receiver hold-off in its own process.
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
        join_none
        for (int k = 0; k < 1630; k++) begin
            mode = $urandom_range(0, 9);
            if (mode < 6) mode = 0;
            else if (mode < 8) mode = 1;
            else if (mode < 9) mode = 2;
            else mode = $urandom_range(0, 3);
            push_quat(rnd_comp(mode), rnd_comp(mode), rnd_comp(mode),
                      ($urandom_range(0, 19) == 0) ? 0 : rnd_comp(mode));
        end
        send_all();
        calm = 1;
        sending_done = 1;
        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (LATENCY * 2) @(posedge i_clk);

        $display("run covered %0d quaternions incl. zero, axis, extreme and gimbal-lock cases,",
                 board.checked);
        $display("with random stalls on both sides and one long output hold-off");
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/q2e_pkg.sv
rtl/q2e_cordic.sv
rtl/quaternion_to_euler_angles_unit.sv
tb/tb_top.sv
